[src/mjg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mjg_pkg;

   localparam int MaxColumns = 256;
   localparam int MaxRows    = 256;
   localparam int CoordW     = 8;
   localparam int SizeW      = 9;
   localparam int ColAddrW   = $clog2(MaxColumns);

   localparam int InDataW  = 24;
   localparam int OutDataW = 40;

   typedef enum logic {
      CSR_MAZE_HEIGHT = 1'b0,
      CSR_MAZE_WIDTH  = 1'b1
   } csr_index_type;

   localparam logic [SizeW-1:0] SizeReset = SizeW'(256);

   typedef struct packed {
      logic                en;
      logic                clear;
      logic [ColAddrW-1:0] addr;
      logic [CoordW-1:0]   row;
   } col_wr_type;

   typedef struct packed {
      logic [CoordW-1:0] row;
      logic [CoordW-1:0] col;
      logic              start;
      logic              node;
   } cell_type;

endpackage
`default_nettype wire

[src/mjg_cell_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
module mjg_cell_decode (
   input  wire logic [mjg_pkg::InDataW-1:0] tdata,
   input  wire logic                        start,
   input  wire logic [mjg_pkg::SizeW-1:0]   maze_height,
   input  wire logic [mjg_pkg::SizeW-1:0]   maze_width,
   output mjg_pkg::cell_type                cell_info
);
   import mjg_pkg::*;

   logic [CoordW-1:0] row;
   logic [CoordW-1:0] col;
   logic              wall;
   logic              up;
   logic              down;
   logic              left;
   logic              right;
   logic              interior;
   logic [SizeW:0]    row_p2;
   logic [SizeW:0]    col_p2;

   always_comb begin
      row    = tdata[7:0];
      col    = tdata[15:8];
      wall   = tdata[16];
      up     = tdata[17];
      down   = tdata[18];
      left   = tdata[19];
      right  = tdata[20];
      row_p2 = (SizeW+1)'(row) + (SizeW+1)'(2);
      col_p2 = (SizeW+1)'(col) + (SizeW+1)'(2);
      interior = (row != '0) && (col != '0)
               && (row_p2 <= (SizeW+1)'(maze_height))
               && (col_p2 <= (SizeW+1)'(maze_width));
      cell_info.row   = row;
      cell_info.col   = col;
      cell_info.start = start;
      cell_info.node  = interior && !wall && !((up && down) || (left && right));
   end

endmodule
`default_nettype wire

[src/mjg_col_store.sv]
`timescale 1ns / 1ps
`default_nettype none
module mjg_col_store (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [mjg_pkg::ColAddrW-1:0] rd_addr,
   output logic      [mjg_pkg::CoordW-1:0]   rd_row,
   input  wire logic [mjg_pkg::ColAddrW-1:0] vld_addr,
   output logic                              vld,
   input  wire mjg_pkg::col_wr_type          wr
);
   import mjg_pkg::*;

   logic [CoordW-1:0]     row_mem [MaxColumns];
   logic [CoordW-1:0]     rd_row_ff;
   logic [MaxColumns-1:0] valid_ff;
   logic [MaxColumns-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         row_mem[wr.addr] <= wr.row;
      end
      if (rd_en) begin
         rd_row_ff <= row_mem[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.clear) begin
         valid_in = '0;
      end
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_row = rd_row_ff;
   assign vld    = valid_ff[vld_addr];

endmodule
`default_nettype wire

[src/maze_junction_graph_builder.sv]
`timescale 1ns / 1ps
`default_nettype none
// Junction extractor for a raster-ordered maze stream. One cell item is taken per clock;
// each produces one result item, registered first by the decode and column-record read
// stage and then by the link compare and write-back into an output register. The per-column
// record of the latest node lives in a 256-entry single-write memory with registered read,
// a valid bit per column in flops, and forwarding for back-to-back cells in the same column.
// Full rate is sustained while rsp_tready stays high. tuser maze_start clears all records.
module maze_junction_graph_builder (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic                         csr_index,
   input  wire logic [mjg_pkg::SizeW-1:0]    csr_wdata,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // [7:0] row, [15:8] col, [16] cell_wall, [17] wall_above, [18] wall_below,
   // [19] wall_left, [20] wall_right, [23:21] zero
   input  wire logic [mjg_pkg::InDataW-1:0]  req_tdata,
   // [0] maze_start
   input  wire logic                         req_tuser,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // [0] is_node, [1] has_up_link, [9:2] up_row, [17:10] up_distance,
   // [18] has_left_link, [26:19] left_col, [34:27] left_distance, [39:35] zero
   output logic      [mjg_pkg::OutDataW-1:0] rsp_tdata
);
   import mjg_pkg::*;

   logic [SizeW-1:0]    height_ff;
   logic [SizeW-1:0]    width_ff;
   cell_type            cell_info;
   cell_type            s1_ff;
   logic                s1_valid_ff;
   logic                s1_adv;
   logic                req_acc;
   logic                fwd_hit_ff;
   logic [CoordW-1:0]   fwd_row_ff;
   logic [CoordW-1:0]   mem_row;
   logic                mem_vld;
   logic [CoordW-1:0]   up_row;
   logic                up_ok;
   logic                row_same;
   logic                left_ok;
   logic                row_valid_ff;
   logic                row_valid_in;
   logic [CoordW-1:0]   row_col_ff;
   logic [CoordW-1:0]   row_col_in;
   logic [CoordW-1:0]   cur_row_ff;
   logic                rsp_valid_ff;
   logic [OutDataW-1:0] rsp_data_ff;
   logic [OutDataW-1:0] rsp_data_in;
   col_wr_type          col_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= SizeReset;
         width_ff  <= SizeReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAZE_HEIGHT: height_ff <= csr_wdata;
            CSR_MAZE_WIDTH:  width_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   mjg_cell_decode u_decode (
      .tdata       (req_tdata),
      .start       (req_tuser),
      .maze_height (height_ff),
      .maze_width  (width_ff),
      .cell_info   (cell_info)
   );

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      col_wr.en    = s1_adv && s1_ff.node;
      col_wr.clear = s1_adv && s1_ff.start;
      col_wr.addr  = ColAddrW'(s1_ff.col);
      col_wr.row   = s1_ff.row;
   end

   mjg_col_store u_col_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_acc),
      .rd_addr  (ColAddrW'(cell_info.col)),
      .rd_row   (mem_row),
      .vld_addr (ColAddrW'(s1_ff.col)),
      .vld      (mem_vld),
      .wr       (col_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // same-column write in the cycle of the read: take the row being written
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff      <= cell_info;
         fwd_hit_ff <= s1_valid_ff && s1_ff.node && (s1_ff.col == cell_info.col);
         fwd_row_ff <= s1_ff.row;
      end
   end

   always_comb begin
      up_row   = fwd_hit_ff ? fwd_row_ff : mem_row;
      up_ok    = !s1_ff.start && mem_vld && (up_row < s1_ff.row);
      row_same = !s1_ff.start && (s1_ff.row == cur_row_ff) && row_valid_ff;
      left_ok  = row_same && (row_col_ff < s1_ff.col);

      rsp_data_in = '0;
      if (s1_ff.node) begin
         rsp_data_in[0] = 1'b1;
         if (up_ok) begin
            rsp_data_in[1]     = 1'b1;
            rsp_data_in[9:2]   = up_row;
            rsp_data_in[17:10] = s1_ff.row - up_row;
         end
         if (left_ok) begin
            rsp_data_in[18]    = 1'b1;
            rsp_data_in[26:19] = row_col_ff;
            rsp_data_in[34:27] = s1_ff.col - row_col_ff;
         end
      end

      row_valid_in = s1_ff.node ? 1'b1 : row_same;
      row_col_in   = s1_ff.node ? s1_ff.col : row_col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
         row_col_ff   <= '0;
         cur_row_ff   <= '0;
      end else if (s1_adv) begin
         row_valid_ff <= row_valid_in;
         row_col_ff   <= row_col_in;
         cur_row_ff   <= s1_ff.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
